// ----- hdl/dsr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the DVB-STP section reassembler.
// No dependencies; imported by dvbstp_section_reassembler.
package dsr_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_START   = 2'd3;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_TIMEOUTS = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  localparam logic [1:0] REG_WANTED_ID    = 2'd0;
  localparam logic [1:0] REG_IDLE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_TIMEOUTS = 2'd2;

  localparam int POS_CRC_BIT    = 0;
  localparam int POS_PAYLOAD_ID = 4;
  localparam int POS_SECTION_HI = 8;
  localparam int POS_SECTION_LO = 9;
  localparam int POS_LAST_LO    = 10;
  localparam int POS_FLAGS      = 11;
  localparam int HEADER_LEN     = 12;
  localparam int PROVIDER_LEN   = 4;
  localparam int CRC_LEN        = 4;

  localparam logic [7:0] WANTED_ID_RESET    = 8'd1;
  localparam logic [7:0] IDLE_LIMIT_RESET   = 8'd30;
  localparam logic [3:0] MAX_TIMEOUTS_RESET = 4'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ----- hdl/dvbstp_section_reassembler.sv -----
`timescale 1ns / 1ps
// DVB-STP section reassembler top level; depends on dsr_pkg.
// Results are registered into the output queue as their item is accepted.
// Throughput: one item per cycle while the output queue holds at most two results;
// an item yields at most two results, which go through a four-entry output queue,
// so the output port (one result a cycle) sets the rate when many items yield two.
// Reset (rst, synchronous, active high) ends the session and restores the registers.
module dvbstp_section_reassembler #(
  parameter int MAX_DATAGRAM = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // op
  input  logic        s_tlast,   // end_of_datagram
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // payload_byte
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dsr_pkg::*;

  localparam int PW = $clog2(MAX_DATAGRAM + 1);

  logic [7:0]  wanted_id;
  logic [7:0]  idle_limit;
  logic [3:0]  max_timeouts;

  logic          active, active_next;
  logic [PW-1:0] pos, pos_next;
  logic          crc_on, crc_on_next;
  logic          id_match, id_match_next;
  logic [11:0]   section, section_next;
  logic [11:0]   last_section, last_section_next;
  logic          prov_flag, prov_flag_next;
  logic [3:0]    ext_len, ext_len_next;
  logic          accepted, accepted_next;
  logic          nul_seen, nul_seen_next;
  logic [7:0]    hold [4];
  logic [7:0]    hold_next [4];
  logic [2:0]    hold_count, hold_count_next;
  logic [11:0]   expected, expected_next;
  logic [3:0]    timeouts, timeouts_next;
  logic [7:0]    idle_secs, idle_secs_next;

  logic          emit_pay, emit_status;
  logic [7:0]    pay_byte, cand;
  logic          cand_valid;
  logic [1:0]    status_kind;
  logic [4:0]    start_pos;
  logic [5:0]    need;
  logic          take;

  result_t       queue [4];
  logic [1:0]    wr_ptr, rd_ptr;
  logic [2:0]    count, count_next;
  logic [1:0]    push_n;
  logic          pop;
  result_t       e0, e1;

  assign pready   = 1'b1;
  assign s_tready = (count <= 3'd2);
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tuser  = queue[rd_ptr].kind;
  assign m_tdata  = queue[rd_ptr].data;
  assign m_tlast  = queue[rd_ptr].last;

  always_comb begin
    case (paddr[3:2])
      REG_WANTED_ID:    prdata = {24'd0, wanted_id};
      REG_IDLE_LIMIT:   prdata = {24'd0, idle_limit};
      REG_MAX_TIMEOUTS: prdata = {28'd0, max_timeouts};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_id    <= WANTED_ID_RESET;
      idle_limit   <= IDLE_LIMIT_RESET;
      max_timeouts <= MAX_TIMEOUTS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_WANTED_ID:    wanted_id <= pwdata[7:0];
        REG_IDLE_LIMIT:   idle_limit <= pwdata[7:0];
        REG_MAX_TIMEOUTS: max_timeouts <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active_next       = active;
    pos_next          = pos;
    crc_on_next       = crc_on;
    id_match_next     = id_match;
    section_next      = section;
    last_section_next = last_section;
    prov_flag_next    = prov_flag;
    ext_len_next      = ext_len;
    accepted_next     = accepted;
    nul_seen_next     = nul_seen;
    hold_next         = hold;
    hold_count_next   = hold_count;
    expected_next     = expected;
    timeouts_next     = timeouts;
    idle_secs_next    = idle_secs;
    emit_pay          = 1'b0;
    emit_status       = 1'b0;
    pay_byte          = s_tdata;
    status_kind       = KIND_COMPLETE;
    cand              = s_tdata;
    cand_valid        = 1'b0;
    start_pos         = 5'(HEADER_LEN) + (prov_flag ? 5'(PROVIDER_LEN) : 5'd0)
                        + {1'b0, ext_len};
    need              = 6'd0;

    if (s_tuser == OP_START) begin
      active_next       = 1'b1;
      expected_next     = 12'd0;
      timeouts_next     = 4'd0;
      idle_secs_next    = 8'd0;
      pos_next          = '0;
      crc_on_next       = 1'b0;
      id_match_next     = 1'b0;
      section_next      = 12'd0;
      last_section_next = 12'd0;
      prov_flag_next    = 1'b0;
      ext_len_next      = 4'd0;
      accepted_next     = 1'b0;
      nul_seen_next     = 1'b0;
      hold_count_next   = 3'd0;
    end else if (active) begin
      case (s_tuser)
        OP_BYTE: begin
          if (pos < PW'(MAX_DATAGRAM)) begin
            pos_next = pos + PW'(1);
            if (pos == PW'(POS_CRC_BIT)) begin
              crc_on_next = s_tdata[0];
            end else if (pos == PW'(POS_PAYLOAD_ID)) begin
              id_match_next = (s_tdata == wanted_id);
            end else if (pos == PW'(POS_SECTION_HI)) begin
              section_next[11:4] = s_tdata;
            end else if (pos == PW'(POS_SECTION_LO)) begin
              section_next[3:0]       = s_tdata[7:4];
              last_section_next[11:8] = s_tdata[3:0];
            end else if (pos == PW'(POS_LAST_LO)) begin
              last_section_next[7:0] = s_tdata;
            end else if (pos == PW'(POS_FLAGS)) begin
              prov_flag_next = s_tdata[4];
              ext_len_next   = s_tdata[3:0];
              if (id_match) begin
                idle_secs_next = 8'd0;
                if (section == expected) begin
                  accepted_next = 1'b1;
                end
              end
            end else if (pos >= PW'(HEADER_LEN) && accepted
                         && pos >= PW'(start_pos)) begin
              if (crc_on) begin
                if (hold_count < 3'd4) begin
                  hold_next[hold_count[1:0]] = s_tdata;
                  hold_count_next = hold_count + 3'd1;
                end else begin
                  cand       = hold[0];
                  cand_valid = 1'b1;
                  hold_next[0] = hold[1];
                  hold_next[1] = hold[2];
                  hold_next[2] = hold[3];
                  hold_next[3] = s_tdata;
                end
              end else begin
                cand_valid = 1'b1;
              end
              if (cand_valid && !nul_seen) begin
                if (cand == 8'd0) begin
                  nul_seen_next = 1'b1;
                end else begin
                  emit_pay = 1'b1;
                  pay_byte = cand;
                end
              end
            end
          end
          if (s_tlast) begin
            timeouts_next = 4'd0;
            need = 6'(HEADER_LEN) + (prov_flag_next ? 6'(PROVIDER_LEN) : 6'd0)
                   + {2'b00, ext_len_next} + (crc_on_next ? 6'(CRC_LEN) : 6'd0);
            if (accepted_next && pos_next >= PW'(need)) begin
              if (section_next == last_section_next) begin
                emit_status = 1'b1;
                status_kind = KIND_COMPLETE;
                active_next = 1'b0;
              end else begin
                expected_next = expected + 12'd1;
              end
            end
            pos_next          = '0;
            crc_on_next       = 1'b0;
            id_match_next     = 1'b0;
            section_next      = 12'd0;
            last_section_next = 12'd0;
            prov_flag_next    = 1'b0;
            ext_len_next      = 4'd0;
            accepted_next     = 1'b0;
            nul_seen_next     = 1'b0;
            hold_count_next   = 3'd0;
          end
        end
        OP_TICK: begin
          if (idle_secs != 8'hFF) begin
            idle_secs_next = idle_secs + 8'd1;
          end
          if (idle_secs_next > idle_limit) begin
            emit_status = 1'b1;
            status_kind = KIND_IDLE;
            active_next = 1'b0;
          end
        end
        OP_TIMEOUT: begin
          if (timeouts != 4'hF) begin
            timeouts_next = timeouts + 4'd1;
          end
          if (timeouts_next >= max_timeouts) begin
            emit_status = 1'b1;
            status_kind = KIND_TIMEOUTS;
            active_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push_n = take ? ({1'b0, emit_pay} + {1'b0, emit_status}) : 2'd0;
    e1.kind = status_kind;
    e1.data = 8'd0;
    e1.last = 1'b1;
    if (emit_pay) begin
      e0.kind = KIND_PAYLOAD;
      e0.data = pay_byte;
      e0.last = !emit_status;
    end else begin
      e0 = e1;
    end
    count_next = count + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= e0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= e1;
    end
    if (take) begin
      hold <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pos          <= '0;
      crc_on       <= 1'b0;
      id_match     <= 1'b0;
      section      <= 12'd0;
      last_section <= 12'd0;
      prov_flag    <= 1'b0;
      ext_len      <= 4'd0;
      accepted     <= 1'b0;
      nul_seen     <= 1'b0;
      hold_count   <= 3'd0;
      expected     <= 12'd0;
      timeouts     <= 4'd0;
      idle_secs    <= 8'd0;
      wr_ptr       <= 2'd0;
      rd_ptr       <= 2'd0;
      count        <= 3'd0;
    end else begin
      if (take) begin
        active       <= active_next;
        pos          <= pos_next;
        crc_on       <= crc_on_next;
        id_match     <= id_match_next;
        section      <= section_next;
        last_section <= last_section_next;
        prov_flag    <= prov_flag_next;
        ext_len      <= ext_len_next;
        accepted     <= accepted_next;
        nul_seen     <= nul_seen_next;
        hold_count   <= hold_count_next;
        expected     <= expected_next;
        timeouts     <= timeouts_next;
        idle_secs    <= idle_secs_next;
      end
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule

// ----- tb/tb_dvbstp_section_reassembler.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dvbstp_section_reassembler; depends on dsr_pkg and the RTL.
// Directed tests and random datagram traffic go in over the stream port, and every result is
// compared with a cycle-free model of the reassembler kept inside this bench.
module tb_dvbstp_section_reassembler;
  import dsr_pkg::*;

  localparam int DATAGRAM_LIMIT = 2048;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HDR_MATCH = 30;
  localparam int HDR_CRC = 29;
  localparam int HDR_PROV = 28;
  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = OP_BYTE;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dvbstp_section_reassembler #(
    .MAX_DATAGRAM(DATAGRAM_LIMIT)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Shadow registers, written only by the stimulus process.
  logic [7:0] cfg_wanted_id;
  logic [7:0] cfg_idle_limit;
  logic [3:0] cfg_max_timeouts;

  // Model state, written only by the checking process.
  logic        sess_on;
  int unsigned dg_pos;
  logic [31:0] hdr;
  logic        dg_taken;
  logic        nul_hit;
  logic [7:0]  crc_hold [4];
  int unsigned hold_cnt;
  logic [11:0] exp_section;
  logic [3:0]  rx_timeouts;
  logic [7:0]  idle_secs;
  result_t     pending_results [$];
  int          error_count = 0;

  int          reg_errors = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 13;
  int          rx_idle_pct = 50;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [7:0]  frame [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void clear_datagram();
    dg_pos = 0;
    hdr = '0;
    dg_taken = 1'b0;
    nul_hit = 1'b0;
    hold_cnt = 0;
    for (int i = 0; i < 4; i++) crc_hold[i] = '0;
  endfunction

  function automatic int unsigned payload_start();
    return HEADER_LEN + (hdr[HDR_PROV] ? PROVIDER_LEN : 0) + hdr[27:24];
  endfunction

  task automatic reset_model();
    sess_on = 1'b0;
    exp_section = '0;
    rx_timeouts = '0;
    idle_secs = '0;
    clear_datagram();
    pending_results.delete();
  endtask

  task automatic reassemble_item(input logic [1:0] op, input logic [7:0] b, input logic eod);
    result_t     burst [$];
    int unsigned pos;
    int unsigned need;
    logic [7:0]  out_b;
    logic        emit;
    if (op == OP_START) begin
      sess_on = 1'b1;
      exp_section = '0;
      rx_timeouts = '0;
      idle_secs = '0;
      clear_datagram();
    end else if (sess_on) begin
      if (op == OP_BYTE) begin
        emit = 1'b0;
        out_b = '0;
        if (dg_pos < DATAGRAM_LIMIT) begin
          pos = dg_pos;
          dg_pos++;
          case (pos)
            POS_CRC_BIT: hdr[HDR_CRC] = b[0];
            POS_PAYLOAD_ID: if (b == cfg_wanted_id) hdr[HDR_MATCH] = 1'b1;
            POS_SECTION_HI: hdr[11:4] = b;
            POS_SECTION_LO: begin
              hdr[3:0] = b[7:4];
              hdr[23:20] = b[3:0];
            end
            POS_LAST_LO: hdr[19:12] = b;
            POS_FLAGS: begin
              hdr[HDR_PROV] = b[4];
              hdr[27:24] = b[3:0];
              if (hdr[HDR_MATCH]) begin
                idle_secs = '0;
                if (hdr[11:0] == exp_section) dg_taken = 1'b1;
              end
            end
            default: begin
              if (pos >= HEADER_LEN && dg_taken && pos >= payload_start()) begin
                if (hdr[HDR_CRC]) begin
                  if (hold_cnt < CRC_LEN) begin
                    crc_hold[hold_cnt] = b;
                    hold_cnt++;
                  end else begin
                    out_b = crc_hold[0];
                    crc_hold[0] = crc_hold[1];
                    crc_hold[1] = crc_hold[2];
                    crc_hold[2] = crc_hold[3];
                    crc_hold[3] = b;
                    emit = 1'b1;
                  end
                end else begin
                  out_b = b;
                  emit = 1'b1;
                end
              end
            end
          endcase
          if (emit && !nul_hit) begin
            if (out_b == 8'h00) nul_hit = 1'b1;
            else burst.insert(burst.size(), make_result(KIND_PAYLOAD, out_b));
          end
        end
        if (eod) begin
          rx_timeouts = '0;
          if (dg_taken) begin
            need = payload_start() + (hdr[HDR_CRC] ? CRC_LEN : 0);
            if (dg_pos >= need) begin
              if (hdr[11:0] == hdr[23:12]) begin
                burst.insert(burst.size(), make_result(KIND_COMPLETE, 8'h00));
                sess_on = 1'b0;
              end else begin
                exp_section = exp_section + 12'd1;
              end
            end
          end
          clear_datagram();
        end
      end else if (op == OP_TICK) begin
        if (idle_secs != 8'hFF) idle_secs++;
        if (idle_secs > cfg_idle_limit) begin
          burst.insert(burst.size(), make_result(KIND_IDLE, 8'h00));
          sess_on = 1'b0;
        end
      end else begin
        if (rx_timeouts != 4'hF) rx_timeouts++;
        if (rx_timeouts >= cfg_max_timeouts) begin
          burst.insert(burst.size(), make_result(KIND_TIMEOUTS, 8'h00));
          sess_on = 1'b0;
        end
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    pending_results = {pending_results, burst};
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (s_tvalid && s_tready) reassemble_item(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d, payload_byte %0h, run_last %0b",
                 m_tuser, m_tdata, m_tlast);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            error_count++;
          end
          if (m_tdata !== want.data) begin
            $error("payload_byte: expected %0h, got %0h", want.data, m_tdata);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, m_tlast);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic void build_datagram(input logic [7:0] pid, input logic [11:0] sect,
                                         input logic [11:0] last_sect, input logic crc,
                                         input logic prov, input logic [3:0] ext,
                                         input int body_len, input int nul_pct);
    frame.delete();
    for (int i = 0; i < HEADER_LEN; i++) frame.insert(frame.size(), rand_byte());
    frame[POS_CRC_BIT] = {frame[POS_CRC_BIT][7:1], crc};
    frame[POS_PAYLOAD_ID] = pid;
    frame[POS_SECTION_HI] = sect[11:4];
    frame[POS_SECTION_LO] = {sect[3:0], last_sect[11:8]};
    frame[POS_LAST_LO] = last_sect[7:0];
    frame[POS_FLAGS] = {frame[POS_FLAGS][7:5], prov, ext};
    repeat ((prov ? PROVIDER_LEN : 0) + ext) frame.insert(frame.size(), rand_byte());
    repeat (body_len) begin
      if ($urandom_range(0, 99) < nul_pct) frame.insert(frame.size(), 8'h00);
      else frame.insert(frame.size(), 8'($urandom_range(1, 255)));
    end
    if (crc) repeat (CRC_LEN) frame.insert(frame.size(), rand_byte());
  endfunction

  // Sends the first len bytes of the frame (all of it when len is zero), marking the final
  // one as the end of the datagram; a tick or timeout may be slipped in before byte inject_at.
  task automatic send_frame(input int len, input int inject_at, input logic [1:0] inject_op);
    int n;
    n = (len <= 0 || len > frame.size()) ? frame.size() : len;
    for (int i = 0; i < n; i++) begin
      if (i == inject_at) send_item(inject_op, rand_byte(), 1'($urandom_range(0, 1)));
      send_item(OP_BYTE, frame[i], i == n - 1);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    wait_idle();
    apb_access(1'b1, idx, value, unused);
    case (idx)
      REG_WANTED_ID: cfg_wanted_id = value[7:0];
      REG_IDLE_LIMIT: cfg_idle_limit = value[7:0];
      REG_MAX_TIMEOUTS: cfg_max_timeouts = value[3:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    logic [31:0] mask;
    mask = (idx == REG_MAX_TIMEOUTS) ? 32'h0000_000F : 32'h0000_00FF;
    apb_access(1'b0, idx, '0, got);
    if ((got & mask) !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, got & mask);
      reg_errors++;
    end
  endtask

  task automatic test_inactive_session();
    build_datagram(cfg_wanted_id, 12'd0, 12'd0, 1'b0, 1'b0, 4'd0, 4, 0);
    send_frame(0, 2, OP_TICK);
    send_item(OP_TIMEOUT, rand_byte(), 1'b1);
    send_item(OP_TICK, rand_byte(), 1'b0);
  endtask

  task automatic test_config_registers();
    s_tvalid <= 1'b0;
    check_reg(REG_WANTED_ID, 32'(WANTED_ID_RESET));
    check_reg(REG_IDLE_LIMIT, 32'(IDLE_LIMIT_RESET));
    check_reg(REG_MAX_TIMEOUTS, 32'(MAX_TIMEOUTS_RESET));
    write_reg(REG_WANTED_ID, 32'h0000_00A5);
    write_reg(REG_IDLE_LIMIT, 32'd255);
    write_reg(REG_MAX_TIMEOUTS, 32'd15);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    check_reg(REG_WANTED_ID, 32'h0000_00A5);
    check_reg(REG_IDLE_LIMIT, 32'd255);
    check_reg(REG_MAX_TIMEOUTS, 32'd15);
  endtask

  task automatic test_payload_and_crc();
    send_item(OP_START, 8'hFF, 1'b1);
    build_datagram(cfg_wanted_id, 12'd0, 12'd2, 1'b0, 1'b0, 4'd0, 6, 0);
    frame[HEADER_LEN] = 8'hFF;
    frame[HEADER_LEN + 1] = 8'h01;
    send_frame(0, -1, OP_TICK);
    build_datagram(cfg_wanted_id, 12'd1, 12'd2, 1'b1, 1'b1, 4'd15, 7, 0);
    send_frame(0, -1, OP_TICK);
    // The final byte is payload and also ends the last section.
    build_datagram(cfg_wanted_id, 12'd2, 12'd2, 1'b0, 1'b0, 4'd3, 5, 0);
    send_frame(0, -1, OP_TICK);
  endtask

  task automatic test_nul_terminator();
    send_item(OP_START, 8'h00, 1'b0);
    build_datagram(cfg_wanted_id, 12'd0, 12'd1, 1'b1, 1'b0, 4'd0, 8, 0);
    frame[HEADER_LEN + 3] = 8'h00;
    frame[HEADER_LEN + 5] = 8'h00;
    send_frame(0, -1, OP_TICK);
    build_datagram(cfg_wanted_id, 12'd1, 12'd1, 1'b0, 1'b0, 4'd0, 4, 0);
    frame[HEADER_LEN] = 8'h00;
    send_frame(0, -1, OP_TICK);
  endtask

  task automatic test_filtering();
    send_item(OP_START, rand_byte(), 1'b0);
    build_datagram(cfg_wanted_id ^ 8'h80, 12'd0, 12'd0, 1'b0, 1'b0, 4'd0, 5, 0);
    send_frame(0, -1, OP_TICK);
    build_datagram(cfg_wanted_id, 12'd5, 12'd5, 1'b0, 1'b0, 4'd0, 5, 0);
    send_frame(0, -1, OP_TICK);
    build_datagram(cfg_wanted_id, 12'd0, 12'd0, 1'b0, 1'b1, 4'd2, 3, 0);
    send_frame(0, -1, OP_TICK);
  endtask

  task automatic test_runt_datagram();
    send_item(OP_START, rand_byte(), 1'b0);
    // Header, provider id, extension and CRC come to exactly 25 bytes here.
    build_datagram(cfg_wanted_id, 12'd0, 12'd1, 1'b1, 1'b1, 4'd5, 0, 0);
    send_frame(24, -1, OP_TICK);
    send_frame(1, -1, OP_TICK);
    send_frame(0, -1, OP_TICK);
    build_datagram(cfg_wanted_id, 12'd1, 12'd1, 1'b1, 1'b0, 4'd0, 5, 0);
    send_frame(0, -1, OP_TICK);
  endtask

  task automatic test_receive_timeouts();
    write_reg(REG_MAX_TIMEOUTS, 32'd4);
    send_item(OP_START, rand_byte(), 1'b0);
    repeat (2) send_item(OP_TIMEOUT, rand_byte(), 1'b0);
    // A timeout inside a datagram leaves it intact, and the datagram end clears the count.
    build_datagram(cfg_wanted_id, 12'd0, 12'd3, 1'b0, 1'b0, 4'd0, 4, 0);
    send_frame(0, 14, OP_TIMEOUT);
    repeat (4) send_item(OP_TIMEOUT, rand_byte(), 1'b1);
    write_reg(REG_MAX_TIMEOUTS, 32'd1);
    send_item(OP_START, rand_byte(), 1'b0);
    send_item(OP_TIMEOUT, rand_byte(), 1'b0);
    write_reg(REG_MAX_TIMEOUTS, 32'd15);
    send_item(OP_START, rand_byte(), 1'b0);
    repeat (16) send_item(OP_TIMEOUT, rand_byte(), 1'b0);
  endtask

  task automatic test_idle_timeout();
    write_reg(REG_IDLE_LIMIT, 32'd1);
    send_item(OP_START, rand_byte(), 1'b0);
    repeat (2) send_item(OP_TICK, rand_byte(), 1'b0);
    // A matching id with the wrong section still resets the idle count.
    send_item(OP_START, rand_byte(), 1'b0);
    send_item(OP_TICK, rand_byte(), 1'b0);
    build_datagram(cfg_wanted_id, 12'd9, 12'd9, 1'b0, 1'b0, 4'd0, 3, 0);
    send_frame(0, -1, OP_TICK);
    repeat (2) send_item(OP_TICK, rand_byte(), 1'b1);
  endtask

  task automatic test_backpressure();
    send_item(OP_START, rand_byte(), 1'b0);
    hold_seq++;
    build_datagram(cfg_wanted_id, 12'd0, 12'd0, 1'b0, 1'b0, 4'd0, 20, 0);
    send_frame(0, -1, OP_TICK);
  endtask

  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    int          choice;
    int          need;
    logic [11:0] sect;
    logic [11:0] last_sect;
    logic        crc;
    logic        prov;
    logic [3:0]  ext;
    logic [1:0]  inj_op;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      // An idle gap lets the model catch up before the next sequence is chosen.
      s_tvalid <= 1'b0;
      @(posedge clk);
      if (!sess_on) begin
        send_item(OP_START, rand_byte(), 1'($urandom_range(0, 1)));
        sect = '0;
      end else begin
        sect = exp_section;
      end
      crc = 1'($urandom_range(0, 1));
      prov = 1'($urandom_range(0, 1));
      ext = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      last_sect = sect + 12'($urandom_range(0, 3));
      inj_op = $urandom_range(0, 1) ? OP_TICK : OP_TIMEOUT;
      choice = $urandom_range(0, 99);
      if (choice < 60) begin
        build_datagram(cfg_wanted_id, sect, last_sect, crc, prov, ext,
                       $urandom_range(0, 12), 4);
        send_frame(0, ($urandom_range(0, 7) == 0) ? $urandom_range(0, frame.size() - 1) : -1,
                   inj_op);
      end else if (choice < 68) begin
        build_datagram(cfg_wanted_id ^ 8'($urandom_range(1, 255)), sect, last_sect, crc, prov,
                       ext, $urandom_range(0, 8), 4);
        send_frame(0, -1, inj_op);
      end else if (choice < 74) begin
        build_datagram(cfg_wanted_id, sect + 12'($urandom_range(1, 4095)), last_sect, crc,
                       prov, ext, $urandom_range(0, 8), 4);
        send_frame(0, -1, inj_op);
      end else if (choice < 82) begin
        build_datagram(cfg_wanted_id, sect, last_sect, crc, prov, ext, $urandom_range(0, 3), 4);
        need = HEADER_LEN + (prov ? PROVIDER_LEN : 0) + ext + (crc ? CRC_LEN : 0);
        send_frame($urandom_range(1, need - 1), -1, inj_op);
      end else if (choice < 88) begin
        repeat ($urandom_range(1, 6))
          send_item(OP_TICK, rand_byte(), 1'($urandom_range(0, 1)));
      end else if (choice < 94) begin
        repeat ($urandom_range(1, 3))
          send_item(OP_TIMEOUT, rand_byte(), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(2'($urandom_range(0, 3)), rand_byte(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    cfg_wanted_id = WANTED_ID_RESET;
    cfg_idle_limit = IDLE_LIMIT_RESET;
    cfg_max_timeouts = MAX_TIMEOUTS_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_inactive_session();
    test_config_registers();
    test_payload_and_crc();
    test_nul_terminator();
    test_filtering();
    test_runt_datagram();
    test_receive_timeouts();
    test_idle_timeout();
    test_backpressure();

    write_reg(REG_WANTED_ID, 32'(rand_byte()));
    write_reg(REG_IDLE_LIMIT, 32'($urandom_range(2, 12)));
    write_reg(REG_MAX_TIMEOUTS, 32'($urandom_range(2, 6)));
    test_random_traffic(15);

    tx_idle_pct = 50;
    rx_idle_pct = 13;
    write_reg(REG_WANTED_ID, 32'd255);
    write_reg(REG_IDLE_LIMIT, 32'd255);
    write_reg(REG_MAX_TIMEOUTS, 32'd15);
    test_random_traffic(15);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_WANTED_ID, 32'd0);
    write_reg(REG_IDLE_LIMIT, 32'd1);
    write_reg(REG_MAX_TIMEOUTS, 32'd1);
    test_random_traffic(15);

    wait_idle();
    if (error_count == 0 && reg_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
